@@ hdl/at_response_line_classifier_macros.svh @@
// Assertion macros for the AT response line classifier.
`ifndef AT_RESPONSE_LINE_CLASSIFIER_MACROS_SVH
`define AT_RESPONSE_LINE_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ALC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, checked also while reset is high.
`define ALC_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ hdl/alc_pkg.sv @@
// Types, constants and match functions shared by the line classifier.
`timescale 1ns / 1ps
`default_nettype none
package alc_pkg;

   localparam int LINE_BYTES    = 128;
   localparam int MAX_EVENTS    = 4;
   localparam int PATTERN_BYTES = 8;
   localparam int NUM_HEADERS   = 4;
   localparam int CNT_W         = $clog2(LINE_BYTES + 1);

   // Text constants in recent-byte order: newest byte in the low bits.
   localparam logic [15:0] TXT_OK    = 16'h4F4B;
   localparam logic [31:0] TXT_FAIL  = 32'h4641494C;
   localparam logic [39:0] TXT_ERROR = 40'h4552524F52;
   localparam logic [7:0]  CH_LF     = 8'h0A;
   localparam logic [7:0]  CH_CR     = 8'h0D;

   typedef enum logic [2:0] {
      ST_OVERFLOW = 3'd0,
      ST_EVENT    = 3'd1,
      ST_EXPECT   = 3'd2,
      ST_OK       = 3'd3,
      ST_FAIL     = 3'd4,
      ST_ERROR    = 3'd5,
      ST_NEWLINE  = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      REG_HEADER_0   = 3'd0,
      REG_HEADER_1   = 3'd1,
      REG_HEADER_2   = 3'd2,
      REG_HEADER_3   = 3'd3,
      REG_EV_LENGTHS = 3'd4,
      REG_EXP_PATTERN = 3'd5,
      REG_EXP_LENGTH = 3'd6,
      REG_EXP_FUZZY  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [NUM_HEADERS-1:0][63:0] header_text;
      logic [15:0]                  event_lengths;
      logic [63:0]                  expect_pattern;
      logic [3:0]                   expect_length;
      logic                         expect_fuzzy;
   } cfg_type;

   typedef struct packed {
      logic       emit;
      status_type status;
      logic [1:0] index;
      logic [7:0] length;
   } result_type;

   // Pattern of len bytes equals the first len bytes of the line.
   function automatic logic prefix_hit(input logic [63:0] pat, input logic [3:0] len,
                                       input logic [63:0] prefix,
                                       input logic [CNT_W-1:0] cnt);
      logic hit;
      hit = (len != 4'd0) && (len <= 4'(PATTERN_BYTES)) && (cnt >= CNT_W'(len));
      for (int k = 0; k < 8; k++) begin
         if ((4'(k) < len) && (prefix[8*k +: 8] != pat[8*k +: 8])) begin
            hit = 1'b0;
         end
      end
      return hit;
   endfunction

   // Pattern of len bytes ends at the newest byte; a zero byte in the line blocks it.
   function automatic logic tail_hit(input logic [63:0] pat, input logic [3:0] len,
                                     input logic [63:0] recent,
                                     input logic [CNT_W-1:0] cnt, input logic zero);
      logic       hit;
      logic [3:0] pos;
      hit = (len != 4'd0) && (len <= 4'd8) && (cnt >= CNT_W'(len)) && !zero;
      for (int j = 0; j < 8; j++) begin
         pos = len - 4'(j) - 4'd1;
         if ((4'(j) < len) && (recent[8*j +: 8] != pat[8*pos[2:0] +: 8])) begin
            hit = 1'b0;
         end
      end
      return hit;
   endfunction

endpackage
`default_nettype wire

@@ hdl/alc_csr.sv @@
// Configuration register file of the line classifier.
`timescale 1ns / 1ps
`default_nettype none
module alc_csr (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           wr_en,
   input  wire logic [2:0]     wr_index,
   input  wire logic [63:0]    wr_data,
   output alc_pkg::cfg_type    cfg
);
   import alc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_index_type'(wr_index))
            REG_HEADER_0:    cfg_in.header_text[0] = wr_data;
            REG_HEADER_1:    cfg_in.header_text[1] = wr_data;
            REG_HEADER_2:    cfg_in.header_text[2] = wr_data;
            REG_HEADER_3:    cfg_in.header_text[3] = wr_data;
            REG_EV_LENGTHS:  cfg_in.event_lengths   = wr_data[15:0];
            REG_EXP_PATTERN: cfg_in.expect_pattern  = wr_data;
            REG_EXP_LENGTH:  cfg_in.expect_length   = wr_data[3:0];
            REG_EXP_FUZZY:   cfg_in.expect_fuzzy    = wr_data[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

@@ hdl/alc_classifier.sv @@
// Line state and combinational classification of one received byte.
`timescale 1ns / 1ps
`default_nettype none
module alc_classifier (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic [7:0]        rx_byte,
   input  alc_pkg::cfg_type       cfg,
   output alc_pkg::result_type    result
);
   import alc_pkg::*;

   logic [CNT_W-1:0] count_ff, count_in, count_nx;
   logic [63:0]      prefix_ff, prefix_in, prefix_nx;
   logic [63:0]      recent_ff, recent_in, recent_nx;
   logic [7:0]       prev_ff, prev_in;
   logic             zero_ff, zero_in, zero_nx;

   logic             overflow;
   logic             ev_hit;
   logic [1:0]       ev_idx;
   logic             exp_hit;
   logic             ok_hit, fail_hit, error_hit;
   logic             crlf;
   logic             restart;

   always_comb begin
      overflow  = (count_ff >= CNT_W'(LINE_BYTES));
      count_nx  = count_ff + CNT_W'(1);
      prefix_nx = prefix_ff;
      for (int k = 0; k < 8; k++) begin
         if (count_ff == CNT_W'(k)) begin
            prefix_nx[8*k +: 8] = rx_byte;
         end
      end
      recent_nx = {recent_ff[55:0], rx_byte};
      zero_nx   = zero_ff | (rx_byte == 8'd0);
   end

   // Lowest matching event entry wins: scan down so it is written last.
   always_comb begin
      ev_hit = 1'b0;
      ev_idx = 2'd0;
      for (int i = MAX_EVENTS - 1; i >= 0; i--) begin
         if (prefix_hit(cfg.header_text[i], cfg.event_lengths[4*i +: 4],
                        prefix_nx, count_nx)) begin
            ev_hit = 1'b1;
            ev_idx = 2'(i);
         end
      end
   end

   always_comb begin
      exp_hit = 1'b0;
      if ((cfg.expect_length != 4'd0) && (cfg.expect_length <= 4'(PATTERN_BYTES))) begin
         if (cfg.expect_fuzzy) begin
            exp_hit = tail_hit(cfg.expect_pattern, cfg.expect_length, recent_nx,
                               count_nx, zero_nx);
         end else begin
            exp_hit = prefix_hit(cfg.expect_pattern, cfg.expect_length, prefix_nx,
                                 count_nx);
         end
      end
      ok_hit    = !zero_nx && (count_nx >= CNT_W'(2)) && (recent_nx[15:0] == TXT_OK);
      fail_hit  = !zero_nx && (count_nx >= CNT_W'(4)) && (recent_nx[31:0] == TXT_FAIL);
      error_hit = !zero_nx && (count_nx >= CNT_W'(5)) && (recent_nx[39:0] == TXT_ERROR);
      crlf      = (rx_byte == CH_LF) && (prev_ff == CH_CR);
   end

   always_comb begin
      result.emit   = 1'b1;
      result.status = ST_NEWLINE;
      result.index  = 2'd0;
      result.length = 8'(count_nx);
      restart       = 1'b1;
      if (overflow) begin
         result.status = ST_OVERFLOW;
         result.length = 8'(LINE_BYTES);
      end else if (ev_hit) begin
         result.status = ST_EVENT;
         result.index  = ev_idx;
      end else if (exp_hit) begin
         result.status = ST_EXPECT;
      end else if (ok_hit) begin
         result.status = ST_OK;
      end else if (fail_hit) begin
         result.status = ST_FAIL;
      end else if (error_hit) begin
         result.status = ST_ERROR;
      end else if (crlf) begin
         // drop a bare CR LF line without a result
         result.emit = (count_nx != CNT_W'(2));
      end else begin
         result.emit = 1'b0;
         restart     = 1'b0;
      end
   end

   always_comb begin
      count_in  = count_ff;
      prefix_in = prefix_ff;
      recent_in = recent_ff;
      prev_in   = prev_ff;
      zero_in   = zero_ff;
      if (step) begin
         if (restart) begin
            count_in  = '0;
            prefix_in = '0;
            recent_in = '0;
            prev_in   = '0;
            zero_in   = 1'b0;
         end else begin
            count_in  = count_nx;
            prefix_in = prefix_nx;
            recent_in = recent_nx;
            prev_in   = rx_byte;
            zero_in   = zero_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         prefix_ff <= '0;
         recent_ff <= '0;
         prev_ff   <= '0;
         zero_ff   <= 1'b0;
      end else begin
         count_ff  <= count_in;
         prefix_ff <= prefix_in;
         recent_ff <= recent_in;
         prev_ff   <= prev_in;
         zero_ff   <= zero_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/at_response_line_classifier.sv @@
// Top level of the AT response line classifier.
// Takes one modem UART byte per transaction and gives at most one result per byte:
// overflow, event header (with its table index), expected reply, OK, FAIL, ERROR or
// end of line, with the length of the finished line. The block accepts one byte every
// clock cycle while a held result is not stalled by rsp_ready; the result of a byte
// reaches the rsp_ port through the input register, then classification into the result
// register. The rate is set by the line state update, which is combinational and is
// registered for every byte. Configuration registers are written through the csr_ port,
// one per cycle; the user must write them only while no byte is in flight, and the block
// itself does not enforce this. No clearing pass runs after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "at_response_line_classifier_macros.svh"
module at_response_line_classifier (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output wire logic        req_ready,
   input  wire logic [7:0]  req_rx_byte,
   output wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   output wire logic [2:0]  rsp_line_status,
   output wire logic [1:0]  rsp_event_index,
   output wire logic [7:0]  rsp_line_length,
   input  wire logic        csr_valid,
   output wire logic        csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data
);
   import alc_pkg::*;

   cfg_type    cfg;
   result_type result;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   logic [2:0] out_status_ff;
   logic [1:0] out_index_ff;
   logic [7:0] out_length_ff;
   logic       advance;

   alc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   alc_classifier u_classifier (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // advance the held byte whenever the result register can take its outcome
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = result.emit;
      end else begin
         out_valid_in = out_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance && result.emit) begin
         out_status_ff <= result.status;
         out_index_ff  <= result.index;
         out_length_ff <= result.length;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_line_status = out_status_ff;
   assign rsp_event_index = out_index_ff;
   assign rsp_line_length = out_length_ff;

   `ALC_ASSERT_IMPLIES(a_overflow_length, clock, reset, rsp_valid && (rsp_line_status == ST_OVERFLOW), rsp_line_length == 8'(LINE_BYTES))
   `ALC_ASSERT_IMPLIES(a_index_only_event, clock, reset, rsp_valid && (rsp_line_status != ST_EVENT), rsp_event_index == 2'd0)
   `ALC_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_valid && req_ready)

endmodule
`default_nettype wire
